// ----- sv/mfr_pkg.sv -----
// Shared types and constants of the multiframe message reassembler.
package mfr_pkg;

    // Data bytes carried by the first frame of a message and by each later frame.
    localparam logic [2:0] FRAME0_DATA_BYTES = 3'd4;
    localparam logic [2:0] FRAMEN_DATA_BYTES = 3'd7;

    // Stream widths: input is one CAN payload, output is type, length, index and a word.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;
    localparam int WORD_W    = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STORE_HI,
        ST_EMIT
    } mfr_state_t;

endpackage

// ----- sv/mfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module mfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 15
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/multiframe_message_reassembler.sv -----
// Multiframe message reassembler: CAN transport frames in, message words out.
// The first word of a completed message passes the word buffer's registered read and then
// the output register, after a spill write when the completing frame straddles two words.
// A frame that does not complete a message leaves the input ready at once, or after its
// spill write on a straddle; a completing frame holds the input until every word has left
// the single read port of the buffer, one 8-byte word per cycle unless the result channel stalls.
// Reset clears all control state; the word buffer is not cleared, as every byte read out
// has been written earlier in the same message.
module multiframe_message_reassembler #(
    parameter int BUFFER_BYTES = 120
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel: one CAN payload per transaction.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [7:0] frame_counter, [63:8] frame_payload
    // Result channel: one message word per transaction.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] message_type, [14:8] message_length,
                                   // [18:15] word_index, [82:19] word_data, [87:83] zero
    output logic        m_tlast    // last_word
);

    // Byte counts run to BUFFER_BYTES inclusive; the buffer is organised as 8-byte words.
    localparam int CW    = $clog2(BUFFER_BYTES + 1);
    localparam int WORDS = (BUFFER_BYTES + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NW    = $clog2(WORDS + 1);
    localparam int WW    = mfr_pkg::WORD_W;

    // Control and message state.
    mfr_pkg::mfr_state_t state_reg, state_next;
    logic [7:0]    held_type_reg, held_type_next;
    logic [7:0]    next_frame_reg, next_frame_next;
    logic [CW-1:0] rx_reg, rx_next;          // bytes received
    logic [CW-1:0] exp_reg, exp_next;        // bytes expected
    logic          cmpl_reg, cmpl_next;      // message completes after the straddle write
    logic [WW-1:0] tail_reg, tail_next;      // buffer word holding the next free byte
    logic [NW-1:0] words_reg, words_next;    // words to emit
    logic [NW-1:0] rd_cnt_reg, rd_cnt_next;  // words read so far

    // Read pipeline: a word held at the RAM output, then the output register.
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_type_reg, out_type_next;
    logic [6:0]    out_len_reg, out_len_next;
    logic [3:0]    out_idx_reg, out_idx_next;
    logic [WW-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    // Buffer RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    // Frame decode.
    logic [7:0]    frame_counter;
    logic [55:0]   frame_payload;
    logic          accept;
    logic          frame0;
    logic          in_seq;
    logic [15:0]   len_raw;
    logic [CW-1:0] len_cut;
    logic [CW-1:0] rem_bytes;
    logic [CW-1:0] rx_base;
    logic [CW-1:0] rx_new;
    logic [CW-1:0] exp_new;
    logic [CW-1:0] wi_full;
    logic [CW:0]   words_sum;
    logic [2:0]    offs;
    logic [2:0]    n_take;
    logic [3:0]    fill_end;
    logic [WW-1:0] data_src;
    logic [WW-1:0] tail_base;
    logic [2*WW-1:0] merged;
    logic          complete;
    logic          straddle;
    logic          capture;
    logic          issue;

    assign frame_counter = s_tdata[7:0];
    assign frame_payload = s_tdata[63:8];
    assign s_tready      = (state_reg == mfr_pkg::ST_IDLE);
    assign accept        = s_tvalid && s_tready;
    assign frame0        = (frame_counter == 8'd0);
    assign in_seq        = frame0 || (frame_counter == next_frame_reg);

    // Declared length of a new message, cut to the buffer size.
    assign len_raw   = {frame_payload[23:16], frame_payload[15:8]};
    assign len_cut   = (len_raw > 16'(BUFFER_BYTES)) ? CW'(BUFFER_BYTES) : CW'(len_raw);
    assign rem_bytes = exp_reg - rx_reg;

    // Merge the new bytes into the current tail word; they may spill into the word after.
    always_comb begin
        logic [7:0] src_byte [8];
        logic [3:0] k;
        logic       hit;
        if (frame0) begin
            rx_base   = '0;
            exp_new   = len_cut;
            tail_base = '0;
            data_src  = {32'd0, frame_payload[55:24]};
            n_take    = (len_cut < CW'(mfr_pkg::FRAME0_DATA_BYTES)) ?
                        len_cut[2:0] : mfr_pkg::FRAME0_DATA_BYTES;
        end else begin
            rx_base   = rx_reg;
            exp_new   = exp_reg;
            tail_base = tail_reg;
            data_src  = {8'd0, frame_payload};
            n_take    = (rem_bytes > CW'(mfr_pkg::FRAMEN_DATA_BYTES)) ?
                        mfr_pkg::FRAMEN_DATA_BYTES : rem_bytes[2:0];
        end
        offs     = rx_base[2:0];
        rx_new   = rx_base + CW'(n_take);
        fill_end = {1'b0, offs} + {1'b0, n_take};
        complete = (rx_new >= exp_new);
        straddle = (fill_end > 4'd8);
        wi_full  = rx_base >> 3;
        for (int b = 0; b < 8; b++) begin
            src_byte[b] = data_src[b*8 +: 8];
        end
        for (int p = 0; p < 16; p++) begin
            k   = 4'(p) - {1'b0, offs};
            hit = (4'(p) >= {1'b0, offs}) && (k < {1'b0, n_take});
            if (hit) begin
                merged[p*8 +: 8] = src_byte[k[2:0]];
            end else if (p < 8) begin
                merged[p*8 +: 8] = tail_base[p*8 +: 8];
            end else begin
                merged[p*8 +: 8] = 8'd0;
            end
        end
        words_sum = {1'b0, rx_new} + (CW+1)'(7);
    end

    // A word leaves the RAM output whenever the output register is free or being taken.
    assign capture = pend_reg && (!out_valid_reg || m_tready);
    assign issue   = (state_reg == mfr_pkg::ST_EMIT) && (rd_cnt_reg < words_reg) &&
                     (!pend_reg || capture);

    always_comb begin
        state_next      = state_reg;
        held_type_next  = held_type_reg;
        next_frame_next = next_frame_reg;
        rx_next         = rx_reg;
        exp_next        = exp_reg;
        cmpl_next       = cmpl_reg;
        tail_next       = tail_reg;
        words_next      = words_reg;
        rd_cnt_next     = rd_cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = wi_full[AW-1:0];
        ram_wdata       = merged[WW-1:0];

        unique case (state_reg)
            mfr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!in_seq) begin
                        // Unexpected counter: drop the partial message.
                        next_frame_next = 8'd0;
                    end else begin
                        ram_we      = 1'b1;
                        rx_next     = rx_new;
                        exp_next    = exp_new;
                        cmpl_next   = complete;
                        tail_next   = (fill_end >= 4'd8) ? merged[2*WW-1:WW] : merged[WW-1:0];
                        rd_cnt_next = '0;
                        if (rx_new == '0) begin
                            words_next = NW'(1);
                        end else begin
                            words_next = NW'(words_sum >> 3);
                        end
                        if (frame0) begin
                            held_type_next = frame_payload[7:0];
                        end
                        if (complete) begin
                            next_frame_next = 8'd0;
                        end else if (frame0) begin
                            next_frame_next = 8'd1;
                        end else begin
                            next_frame_next = next_frame_reg + 8'd1;
                        end
                        if (straddle) begin
                            state_next = mfr_pkg::ST_STORE_HI;
                        end else if (complete) begin
                            state_next = mfr_pkg::ST_EMIT;
                        end
                    end
                end
            end
            mfr_pkg::ST_STORE_HI: begin
                // Spilled bytes go to the word that now holds the next free byte.
                ram_we     = 1'b1;
                ram_waddr  = AW'(rx_reg >> 3);
                ram_wdata  = tail_reg;
                state_next = cmpl_reg ? mfr_pkg::ST_EMIT : mfr_pkg::ST_IDLE;
            end
            mfr_pkg::ST_EMIT: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + NW'(1);
                end
                if ((rd_cnt_reg == words_reg) && (!pend_reg || capture)) begin
                    state_next = mfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfr_pkg::ST_IDLE;
            end
        endcase
    end

    assign ram_re    = issue;
    assign ram_raddr = rd_cnt_reg[AW-1:0];

    // Read pipeline and output register; bytes past the message length read as zero.
    always_comb begin
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_type_next  = out_type_reg;
        out_len_next   = out_len_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (capture) begin
            out_valid_next = 1'b1;
            out_type_next  = held_type_reg;
            out_len_next   = 7'(rx_reg);
            out_idx_next   = 4'(pend_idx_reg);
            out_last_next  = pend_last_reg;
            for (int b = 0; b < 8; b++) begin
                if (16'({pend_idx_reg, 3'(b)}) < 16'(rx_reg)) begin
                    out_data_next[b*8 +: 8] = ram_rdata[b*8 +: 8];
                end else begin
                    out_data_next[b*8 +: 8] = 8'd0;
                end
            end
            pend_next = 1'b0;
        end
        if (issue) begin
            pend_next      = 1'b1;
            pend_idx_next  = rd_cnt_reg[AW-1:0];
            pend_last_next = ((rd_cnt_reg + NW'(1)) == words_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mfr_pkg::ST_IDLE;
            held_type_reg  <= 8'd0;
            next_frame_reg <= 8'd0;
            rx_reg         <= '0;
            exp_reg        <= '0;
            cmpl_reg       <= 1'b0;
            words_reg      <= '0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_type_reg  <= held_type_next;
            next_frame_reg <= next_frame_next;
            rx_reg         <= rx_next;
            exp_reg        <= exp_next;
            cmpl_reg       <= cmpl_next;
            words_reg      <= words_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_reg      <= tail_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        out_type_reg  <= out_type_next;
        out_len_reg   <= out_len_next;
        out_idx_reg   <= out_idx_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    mfr_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_buf_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg, out_idx_reg, out_len_reg, out_type_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // Emission ends only once every word of the message has been read.
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfr_pkg::ST_EMIT && state_next == mfr_pkg::ST_IDLE)
        |-> (rd_cnt_reg == words_reg))
        else $error("emission left before all words were read");

    // While a message is open, fewer bytes than declared have been stored.
    a_rx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_frame_reg != 8'd0) |-> (rx_reg < exp_reg))
        else $error("bytes received reached the expected count on an open message");

    // The straddle write only follows an accepted frame.
    a_store_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfr_pkg::ST_STORE_HI) |-> $past(s_tvalid && s_tready))
        else $error("straddle write without an accepted frame");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the multiframe message reassembler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUFFER_BYTES = 120;
    // Random frames sent after the directed part.
    localparam int RANDOM_FRAMES = 300;
    // Cycles without any transaction on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    // One word of a completed message, as it should appear on the result channel.
    typedef struct packed {
        logic [7:0]  mtype;
        logic [6:0]  mlen;
        logic [3:0]  idx;
        logic [63:0] data;
        logic        last;
    } msg_word_t;

    // Tracks the reassembly state of the block and holds the words it must still emit.
    class reassembly_checker;
        logic [7:0]  msg_bytes [BUFFER_BYTES];
        logic [7:0]  held_type;
        logic [7:0]  next_frame;
        int unsigned got;
        int unsigned want;
        msg_word_t   expected_words [$];
        int unsigned fails;

        function new();
            foreach (msg_bytes[i]) msg_bytes[i] = 8'd0;
            held_type  = 8'd0;
            next_frame = 8'd0;
            got        = 0;
            want       = 0;
            fails      = 0;
        endfunction

        // Applies one accepted frame and queues the words of any message it completes.
        function void note_frame(logic [7:0] ctr, logic [55:0] pl);
            int unsigned n;
            int unsigned len;
            int unsigned words;
            logic [63:0] data;
            bit          complete;
            complete = 1'b0;
            if (ctr == 8'd0) begin
                // First frame: type, little-endian length, then up to four data bytes.
                len = {pl[23:16], pl[15:8]};
                held_type = pl[7:0];
                if (len > BUFFER_BYTES) len = BUFFER_BYTES;
                want = len;
                n = (len < mfr_pkg::FRAME0_DATA_BYTES) ? len : mfr_pkg::FRAME0_DATA_BYTES;
                foreach (msg_bytes[i]) msg_bytes[i] = 8'd0;
                for (int i = 0; i < n; i++) msg_bytes[i] = pl[8*(3+i) +: 8];
                got = n;
                complete = (got >= want);
                next_frame = complete ? 8'd0 : 8'd1;
            end else if (ctr == next_frame) begin
                n = (want > got) ? want - got : 0;
                if (n > mfr_pkg::FRAMEN_DATA_BYTES) n = mfr_pkg::FRAMEN_DATA_BYTES;
                for (int i = 0; i < n; i++) begin
                    if (got + i < BUFFER_BYTES) msg_bytes[got + i] = pl[8*i +: 8];
                end
                got += n;
                complete = (got >= want);
                next_frame = complete ? 8'd0 : next_frame + 8'd1;
            end else begin
                // Out-of-sequence counter: the partial message is dropped silently.
                next_frame = 8'd0;
            end
            if (complete) begin
                words = (got + 7) / 8;
                if (words == 0) words = 1;
                for (int w = 0; w < words; w++) begin
                    data = '0;
                    for (int b = 0; b < 8; b++) begin
                        if (w * 8 + b < got) data[8*b +: 8] = msg_bytes[w * 8 + b];
                    end
                    expected_words.push_back('{held_type, 7'(got), 4'(w), data,
                                               (w + 1 == words)});
                end
            end
        endfunction

        // Compares one accepted result transaction with the oldest outstanding word.
        function void check_word(msg_word_t act);
            msg_word_t exp_w;
            if (expected_words.size() == 0) begin
                $error("result transaction with no word outstanding: tdata %h last %b",
                       {act.data, act.idx, act.mlen, act.mtype}, act.last);
                fails++;
                return;
            end
            exp_w = expected_words.pop_front();
            if (act.mtype !== exp_w.mtype) begin
                $error("message_type: expected %0d, actual %0d", exp_w.mtype, act.mtype);
                fails++;
            end
            if (act.mlen !== exp_w.mlen) begin
                $error("message_length: expected %0d, actual %0d", exp_w.mlen, act.mlen);
                fails++;
            end
            if (act.idx !== exp_w.idx) begin
                $error("word_index: expected %0d, actual %0d", exp_w.idx, act.idx);
                fails++;
            end
            if (act.data !== exp_w.data) begin
                $error("word_data: expected %h, actual %h", exp_w.data, act.data);
                fails++;
            end
            if (act.last !== exp_w.last) begin
                $error("last_word: expected %0d, actual %0d", exp_w.last, act.last);
                fails++;
            end
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mfr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mfr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    reassembly_checker chk = new();
    // Set during a stretch of the run in which neither side inserts idle cycles.
    bit                no_idle = 1'b0;
    int unsigned       frames_sent = 0;
    int unsigned       quiet_cycles = 0;

    multiframe_message_reassembler #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5ns aclk = ~aclk;

    // The receiver holds off at random about 30 percent of the time, except in the busy stretch.
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
    end

    // Monitor: every transaction is sampled at the edge that completes it, before the
    // nonblocking updates of that edge land, so the order of processes does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                chk.note_frame(s_tdata[7:0], s_tdata[63:8]);
            end
            if (m_tvalid && m_tready) begin
                chk.check_word('{m_tdata[7:0], m_tdata[14:8], m_tdata[18:15],
                                 m_tdata[82:19], m_tlast});
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [55:0] rand_bytes7();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[55:0];
    endfunction

    // Offers one frame, with random idle cycles ahead of it, and returns at the edge of
    // its transaction. tvalid stays high on return so back-to-back frames need no gap.
    task automatic send_frame(input logic [7:0] ctr, input logic [55:0] pl);
        while (!no_idle && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pl, ctr};
        do @(posedge aclk); while (!s_tready);
        frames_sent++;
    endtask

    // Withdraws the sender until every outstanding word has been received.
    task automatic drain_words();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chk.expected_words.size() != 0);
    endtask

    // Sends a message in sequence. A non-negative cut sends that many follow-on frames
    // and then one frame whose counter is out of sequence.
    task automatic send_message(input logic [7:0] mtype, input logic [15:0] len_field,
                                input int cut);
        int unsigned eff;
        int unsigned later;
        logic [55:0] pl;
        logic [7:0]  bad;
        eff = (len_field > BUFFER_BYTES) ? BUFFER_BYTES : len_field;
        later = (eff > mfr_pkg::FRAME0_DATA_BYTES) ?
                (eff - mfr_pkg::FRAME0_DATA_BYTES + 6) / 7 : 0;
        pl = rand_bytes7();
        pl[23:0] = {len_field, mtype};
        send_frame(8'd0, pl);
        for (int k = 1; k <= later; k++) begin
            if (cut >= 0 && k > cut) begin
                do bad = 8'($urandom_range(0, 255)); while (bad == 8'(k));
                send_frame(bad, rand_bytes7());
                return;
            end
            send_frame(8'(k), rand_bytes7());
        end
    endtask

    // Mostly short messages, some long ones and some whose length exceeds the buffer.
    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 16'($urandom_range(0, 24));
        if (roll < 85) return 16'($urandom_range(25, BUFFER_BYTES));
        return 16'($urandom());
    endfunction

    initial begin
        int unsigned msgs;
        int unsigned roll;
        int unsigned eff;
        logic [55:0] first_pl;
        msgs = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. A zero length completes at once with one all-zero word.
        send_message(8'h00, 16'd0, -1);
        // Four bytes fill the first frame exactly; the type and data bytes are all ones.
        send_frame(8'd0, {32'hFFFF_FFFF, 16'd4, 8'hFF});
        // A highest counter while waiting for a first frame is ignored.
        send_frame(8'hFF, '1);
        // An out-of-sequence counter drops the message under way.
        first_pl = rand_bytes7();
        first_pl[23:0] = {16'd20, 8'h5A};
        send_frame(8'd0, first_pl);
        send_frame(8'd1, rand_bytes7());
        send_frame(8'd3, rand_bytes7());
        // The largest length field is cut to the buffer size: fifteen words.
        send_message(8'hC3, 16'hFFFF, -1);
        drain_words();

        // Random part: mostly well-formed messages, some broken ones and stray frames.
        while (frames_sent < 24 + RANDOM_FRAMES) begin
            no_idle = (frames_sent >= 150 && frames_sent < 230);
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                send_message(8'($urandom_range(0, 255)), pick_length(), -1);
            end else if (roll < 88) begin
                eff = $urandom_range(mfr_pkg::FRAME0_DATA_BYTES + 1, BUFFER_BYTES);
                send_message(8'($urandom_range(0, 255)), 16'(eff),
                             $urandom_range(0,
                                 (eff - mfr_pkg::FRAME0_DATA_BYTES + 6) / 7 - 1));
            end else begin
                send_frame(8'($urandom_range(0, 255)), rand_bytes7());
            end
            msgs++;
            if (msgs % 25 == 0) drain_words();
        end
        no_idle = 1'b0;

        drain_words();
        repeat (40) @(posedge aclk);
        if (chk.expected_words.size() != 0) begin
            $error("%0d words never received", chk.expected_words.size());
            chk.fails++;
        end
        if (chk.fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
